FILE: sv/stci_pkg.sv
`timescale 1ns / 1ps

package stci_pkg;

    localparam int STACK_DEPTH = 4;
    localparam int NUM_VARS    = 32;
    localparam int ADDR_WIDTH  = 24;

    localparam int SL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SI_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VI_W  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    // Jump targets carry 24 bits; the address register may be narrower or wider.
    localparam int TGT_W = (ADDR_WIDTH < 24) ? ADDR_WIDTH : 24;

    // Event kinds.
    localparam logic [3:0] EV_NOTE    = 4'd0;
    localparam logic [3:0] EV_WAIT    = 4'd1;
    localparam logic [3:0] EV_PROGRAM = 4'd2;
    localparam logic [3:0] EV_TRACK   = 4'd3;
    localparam logic [3:0] EV_JUMP    = 4'd4;
    localparam logic [3:0] EV_PARAM   = 4'd5;
    localparam logic [3:0] EV_TIE     = 4'd6;
    localparam logic [3:0] EV_TEMPO   = 4'd7;
    localparam logic [3:0] EV_STOP    = 4'd8;
    localparam logic [3:0] EV_UNKNOWN = 4'd9;
    localparam logic [3:0] EV_ERROR   = 4'd10;

    // Error codes.
    localparam logic [7:0] ERR_STACK_FULL  = 8'd0;
    localparam logic [7:0] ERR_STACK_EMPTY = 8'd1;
    localparam logic [7:0] ERR_STACK_TYPE  = 8'd2;
    localparam logic [7:0] ERR_VAR_RANGE   = 8'd3;
    localparam logic [7:0] ERR_NO_LENGTH   = 8'd4;

    // Parameter ids.
    localparam logic [7:0] PID_PAN         = 8'd0;
    localparam logic [7:0] PID_VOLUME      = 8'd1;
    localparam logic [7:0] PID_TRANSPOSE   = 8'd2;
    localparam logic [7:0] PID_BEND        = 8'd3;
    localparam logic [7:0] PID_BEND_RANGE  = 8'd4;
    localparam logic [7:0] PID_PRIORITY    = 8'd5;
    localparam logic [7:0] PID_NOTE_WAIT   = 8'd6;
    localparam logic [7:0] PID_PORTA_START = 8'd7;
    localparam logic [7:0] PID_MOD_BASE    = 8'd8;
    localparam logic [7:0] PID_PORTA       = 8'd12;
    localparam logic [7:0] PID_EXPRESSION  = 8'd18;
    localparam logic [7:0] PID_MOD_DELAY   = 8'd19;
    localparam logic [7:0] PID_SWEEP       = 8'd20;

    // Command codes.
    localparam logic [7:0] CMD_WAIT        = 8'h80;
    localparam logic [7:0] CMD_PROGRAM     = 8'h81;
    localparam logic [7:0] CMD_TRACK       = 8'h93;
    localparam logic [7:0] CMD_JUMP        = 8'h94;
    localparam logic [7:0] CMD_CALL        = 8'h95;
    localparam logic [7:0] CMD_PFX_RND     = 8'hA0;
    localparam logic [7:0] CMD_PFX_VAR     = 8'hA1;
    localparam logic [7:0] CMD_IF          = 8'hA2;
    localparam logic [7:0] CMD_VAR_SET     = 8'hB0;
    localparam logic [7:0] CMD_VAR_ADD     = 8'hB1;
    localparam logic [7:0] CMD_VAR_SUB     = 8'hB2;
    localparam logic [7:0] CMD_VAR_MUL     = 8'hB3;
    localparam logic [7:0] CMD_VAR_DIV     = 8'hB4;
    localparam logic [7:0] CMD_VAR_SHIFT   = 8'hB5;
    localparam logic [7:0] CMD_VAR_RAND    = 8'hB6;
    localparam logic [7:0] CMD_VAR_HOLE    = 8'hB7;
    localparam logic [7:0] CMD_CMP_EQ      = 8'hB8;
    localparam logic [7:0] CMD_CMP_GE      = 8'hB9;
    localparam logic [7:0] CMD_CMP_GT      = 8'hBA;
    localparam logic [7:0] CMD_CMP_LE      = 8'hBB;
    localparam logic [7:0] CMD_CMP_LT      = 8'hBC;
    localparam logic [7:0] CMD_CMP_NE      = 8'hBD;
    localparam logic [7:0] CMD_PAN         = 8'hC0;
    localparam logic [7:0] CMD_VOLUME      = 8'hC1;
    localparam logic [7:0] CMD_ARG_SKIP    = 8'hC2;
    localparam logic [7:0] CMD_TRANSPOSE   = 8'hC3;
    localparam logic [7:0] CMD_BEND        = 8'hC4;
    localparam logic [7:0] CMD_BEND_RANGE  = 8'hC5;
    localparam logic [7:0] CMD_PRIORITY    = 8'hC6;
    localparam logic [7:0] CMD_NOTE_WAIT   = 8'hC7;
    localparam logic [7:0] CMD_TIE         = 8'hC8;
    localparam logic [7:0] CMD_PORTA_START = 8'hC9;
    localparam logic [7:0] CMD_MOD_FIRST   = 8'hCA;
    localparam logic [7:0] CMD_MOD_LAST    = 8'hCD;
    localparam logic [7:0] CMD_PORTA       = 8'hCE;
    localparam logic [7:0] CMD_ENV_FIRST   = 8'hCF;
    localparam logic [7:0] CMD_ENV_LAST    = 8'hD3;
    localparam logic [7:0] CMD_LOOP_START  = 8'hD4;
    localparam logic [7:0] CMD_EXPRESSION  = 8'hD5;
    localparam logic [7:0] CMD_PRINT       = 8'hD6;
    localparam logic [7:0] CMD_MOD_DELAY   = 8'hE0;
    localparam logic [7:0] CMD_TEMPO       = 8'hE1;
    localparam logic [7:0] CMD_SWEEP       = 8'hE3;
    localparam logic [7:0] CMD_LOOP_END    = 8'hFC;
    localparam logic [7:0] CMD_RETURN      = 8'hFD;
    localparam logic [7:0] CMD_ALLOC       = 8'hFE;
    localparam logic [7:0] CMD_END         = 8'hFF;

    // Queue entry kinds.
    localparam logic [1:0] ENT_EXEC    = 2'd0;
    localparam logic [1:0] ENT_ERR_LEN = 2'd1;
    localparam logic [1:0] ENT_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cmd;
        logic [31:0] acc;
        logic [7:0]  vel;
    } entry_t;

    typedef struct packed {
        logic compare_flag;
        logic back_idle;
    } status_t;

    typedef struct packed {
        logic                  addr_load;
        logic [ADDR_WIDTH-1:0] addr_value;
        logic                  seed_load;
        logic [15:0]           seed_value;
    } cfg_t;

    typedef struct packed {
        logic       known;
        logic [3:0] len;
    } len_t;

    function automatic logic var_group(input logic [7:0] c);
        return (c >= CMD_VAR_SET) && (c <= CMD_CMP_NE);
    endfunction

    function automatic len_t main_len(input logic [7:0] c);
        len_t r;
        r.known = 1'b1;
        r.len   = 4'd0;
        if (c == CMD_TRACK) begin
            r.len = 4'd4;
        end else if (c == CMD_JUMP || c == CMD_CALL) begin
            r.len = 4'd3;
        end else if (var_group(c) && c != CMD_VAR_HOLE) begin
            r.len = 4'd3;
        end else if (c >= CMD_PAN && c <= CMD_PRINT) begin
            r.len = 4'd1;
        end else if (c == CMD_MOD_DELAY || c == CMD_TEMPO || c == CMD_SWEEP
                     || c == CMD_ALLOC) begin
            r.len = 4'd2;
        end else if (c == CMD_LOOP_END || c == CMD_RETURN || c == CMD_END) begin
            r.len = 4'd0;
        end else begin
            r.known = 1'b0;
        end
        return r;
    endfunction

    function automatic len_t sub_len(input logic [7:0] c, input logic rnd);
        len_t r;
        logic shared;
        shared = (c >= CMD_PAN && c <= CMD_BEND_RANGE)
              || (c >= CMD_MOD_FIRST && c <= CMD_MOD_LAST)
              || (c >= CMD_ENV_FIRST && c <= CMD_ENV_LAST)
              || c == CMD_EXPRESSION || c == CMD_MOD_DELAY || c == CMD_SWEEP;
        r.known = 1'b1;
        r.len   = 4'd0;
        if (c < CMD_WAIT || (var_group(c) && c != CMD_VAR_HOLE)) begin
            r.len = rnd ? 4'd5 : 4'd2;
        end else if (c == CMD_WAIT || c == CMD_PROGRAM || shared
                     || (!rnd && c == CMD_LOOP_START)) begin
            r.len = rnd ? 4'd4 : 4'd1;
        end else begin
            r.known = 1'b0;
        end
        return r;
    endfunction

    // Commands after which the front waits for the back to finish: they move
    // the address or the stack, or change a variable or the compare flag.
    function automatic logic is_barrier(input logic [7:0] c);
        return var_group(c) || c == CMD_JUMP || c == CMD_CALL || c == CMD_LOOP_START
            || c == CMD_LOOP_END || c == CMD_RETURN;
    endfunction

endpackage

FILE: sv/stci_queue.sv
`timescale 1ns / 1ps

module stci_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  stci_pkg::entry_t push_entry,
    input  logic             pop,
    output stci_pkg::entry_t head,
    output logic             full,
    output logic             empty
);
    import stci_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/stci_front.sv
`timescale 1ns / 1ps

module stci_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_seq_byte,
    input  stci_pkg::status_t status,
    input  logic              q_full,
    input  logic              q_empty,
    output logic              push,
    output stci_pkg::entry_t  push_entry,
    output logic              byte_taken
);
    import stci_pkg::*;

    localparam logic [3:0] PS_CMD     = 4'd0;
    localparam logic [3:0] PS_ARGS    = 4'd1;
    localparam logic [3:0] PS_VEL     = 4'd2;
    localparam logic [3:0] PS_VARLEN  = 4'd3;
    localparam logic [3:0] PS_SUB_RND = 4'd4;
    localparam logic [3:0] PS_SUB_VAR = 4'd5;
    localparam logic [3:0] PS_SKIP    = 4'd6;
    localparam logic [3:0] PS_SKIPCMD = 4'd7;
    localparam logic [3:0] PS_SKIPVEL = 4'd8;
    localparam logic [3:0] PS_SKIPVAR = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  vel_reg, vel_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [3:0]  skip_reg, skip_next;
    logic        barrier_reg, barrier_next;
    logic [1:0]  ent_kind;
    logic [7:0]  b;
    logic [2:0]  cnt_inc;
    len_t        ml;
    len_t        sl;

    assign s_ready    = !barrier_reg && !q_full;
    assign byte_taken = s_valid && s_ready;
    assign b          = s_seq_byte;
    assign cnt_inc    = cnt_reg + 3'd1;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        acc_next     = acc_reg;
        vel_next     = vel_reg;
        cnt_next     = cnt_reg;
        skip_next    = skip_reg;
        barrier_next = barrier_reg;
        push         = 1'b0;
        ent_kind     = ENT_EXEC;
        ml           = main_len(b);
        sl           = sub_len(b, state_reg == PS_SUB_RND);

        if (barrier_reg && q_empty && status.back_idle) begin
            barrier_next = 1'b0;
        end

        if (byte_taken) begin
            unique case (state_reg)
                PS_CMD: begin
                    cmd_next = b;
                    acc_next = 32'd0;
                    cnt_next = 3'd0;
                    priority if (b < CMD_WAIT) begin
                        state_next = PS_VEL;
                    end else if (b == CMD_WAIT || b == CMD_PROGRAM) begin
                        state_next = PS_VARLEN;
                    end else if (b == CMD_PFX_RND) begin
                        state_next = PS_SUB_RND;
                    end else if (b == CMD_PFX_VAR) begin
                        state_next = PS_SUB_VAR;
                    end else if (b == CMD_IF) begin
                        if (!status.compare_flag) begin
                            state_next = PS_SKIPCMD;
                        end
                    end else if (!ml.known) begin
                        push     = 1'b1;
                        ent_kind = ENT_ERR_LEN;
                    end else if (ml.len == 4'd0) begin
                        push = 1'b1;
                    end else begin
                        skip_next  = ml.len;
                        state_next = PS_ARGS;
                    end
                end
                PS_ARGS: begin
                    acc_next = acc_reg | (32'(b) << {cnt_reg[1:0], 3'b000});
                    cnt_next = cnt_inc;
                    if ({1'b0, cnt_inc} >= skip_reg) begin
                        state_next = PS_CMD;
                        push       = 1'b1;
                    end
                end
                PS_VEL: begin
                    vel_next   = b;
                    acc_next   = 32'd0;
                    state_next = PS_VARLEN;
                end
                PS_VARLEN: begin
                    acc_next = {acc_reg[24:0], b[6:0]};
                    if (!b[7]) begin
                        state_next = PS_CMD;
                        push       = 1'b1;
                    end
                end
                PS_SUB_RND, PS_SUB_VAR: begin
                    acc_next = 32'(b);
                    if (!sl.known) begin
                        state_next = PS_CMD;
                        push       = 1'b1;
                        ent_kind   = ENT_ERR_LEN;
                    end else begin
                        skip_next  = sl.len;
                        state_next = PS_SKIP;
                    end
                end
                PS_SKIP: begin
                    if (skip_reg > 4'd1) begin
                        skip_next = skip_reg - 4'd1;
                    end else begin
                        skip_next  = 4'd0;
                        state_next = PS_CMD;
                        if (cmd_reg != CMD_IF) begin
                            push     = 1'b1;
                            ent_kind = ENT_UNKNOWN;
                        end
                    end
                end
                PS_SKIPCMD: begin
                    priority if (b < CMD_WAIT) begin
                        state_next = PS_SKIPVEL;
                    end else if (b == CMD_WAIT || b == CMD_PROGRAM) begin
                        state_next = PS_SKIPVAR;
                    end else if (b == CMD_PFX_RND) begin
                        state_next = PS_SUB_RND;
                    end else if (b == CMD_PFX_VAR) begin
                        state_next = PS_SUB_VAR;
                    end else if (b == CMD_IF) begin
                        state_next = PS_SKIPCMD;
                    end else if (b == CMD_END) begin
                        // Inside a skip the end command carries one argument byte.
                        skip_next  = 4'd1;
                        state_next = PS_SKIP;
                    end else if (!ml.known) begin
                        state_next = PS_CMD;
                        push       = 1'b1;
                        ent_kind   = ENT_ERR_LEN;
                    end else if (ml.len == 4'd0) begin
                        state_next = PS_CMD;
                    end else begin
                        skip_next  = ml.len;
                        state_next = PS_SKIP;
                    end
                end
                PS_SKIPVEL: begin
                    state_next = PS_SKIPVAR;
                end
                PS_SKIPVAR: begin
                    if (!b[7]) begin
                        state_next = PS_CMD;
                    end
                end
                default: begin
                    state_next = PS_CMD;
                end
            endcase
        end

        if (push && ent_kind == ENT_EXEC && is_barrier(cmd_next)) begin
            barrier_next = 1'b1;
        end

        push_entry = '{kind: ent_kind, cmd: cmd_next, acc: acc_next, vel: vel_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PS_CMD;
            cmd_reg     <= 8'd0;
            acc_reg     <= 32'd0;
            vel_reg     <= 8'd0;
            cnt_reg     <= 3'd0;
            skip_reg    <= 4'd0;
            barrier_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            acc_reg     <= acc_next;
            vel_reg     <= vel_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            barrier_reg <= barrier_next;
        end
    end

endmodule

FILE: sv/stci_divider.sv
`timescale 1ns / 1ps

module stci_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [15:0] quotient,
    output logic [16:0] remainder
);
    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] shifted;
    logic [17:0] diff;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        shifted   = {rem_reg, quo_reg[15]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = 17'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[17]) begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = shifted[16:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

FILE: sv/stci_back.sv
`timescale 1ns / 1ps

module stci_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  stci_pkg::cfg_t     cfg,
    input  logic               byte_taken,
    input  stci_pkg::entry_t   head,
    input  logic               q_empty,
    output logic               q_pop,
    output stci_pkg::status_t  status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_kind,
    output logic [7:0]         m_arg_index,
    output logic signed [15:0] m_arg_value,
    output logic [31:0]        m_arg_long
);
    import stci_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    entry_t                ent_reg;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [15:0]           var_reg [NUM_VARS];
    logic [ADDR_WIDTH-1:0] stk_addr_reg [STACK_DEPTH];
    logic [7:0]            stk_count_reg [STACK_DEPTH];
    logic                  stk_loop_reg [STACK_DEPTH];
    logic [SL_W-1:0]       level_reg, level_next;
    logic                  flag_reg, flag_next;
    logic [7:0]            trans_reg, trans_next;
    logic [15:0]           rnd_reg, rnd_next;

    logic [3:0]            ev_kind_reg, ev_kind_next;
    logic [7:0]            ev_idx_reg, ev_idx_next;
    logic [15:0]           ev_val_reg, ev_val_next;
    logic [31:0]           ev_long_reg, ev_long_next;

    logic                  m_valid_reg, m_valid_next;
    logic [3:0]            m_kind_reg;
    logic [7:0]            m_idx_reg;
    logic [15:0]           m_val_reg;
    logic [31:0]           m_long_reg;
    logic                  out_load;

    logic [VI_W-1:0]       dvar_reg, dvar_next;
    logic                  dmod_reg, dmod_next;
    logic                  dneg_reg, dneg_next;

    logic                  var_we;
    logic [VI_W-1:0]       var_widx;
    logic [15:0]           var_wdata;
    logic                  stk_we;
    logic [SI_W-1:0]       stk_widx;
    logic [ADDR_WIDTH-1:0] stk_waddr;
    logic [7:0]            stk_wcount;
    logic                  stk_wloop;

    logic                  div_start;
    logic [15:0]           div_dvd;
    logic [16:0]           div_dvs;
    logic                  div_busy;
    logic                  div_done;
    logic [15:0]           div_quo;
    logic [16:0]           div_rem;

    logic [7:0]            c;
    logic [31:0]           a;
    logic [7:0]            b0;
    logic signed [15:0]    val;
    logic signed [15:0]    v;
    logic                  vid_ok;
    logic [VI_W-1:0]       vid;
    logic [ADDR_WIDTH-1:0] target;
    logic [SL_W-1:0]       lvl_m1;
    logic [SI_W-1:0]       top_idx;
    logic [7:0]            cnt_dec;
    logic signed [9:0]     note_sum;
    logic signed [9:0]     porta_sum;
    logic [6:0]            note_clamp;
    logic [6:0]            porta_clamp;
    logic signed [31:0]    product;
    logic [16:0]           shift_n;
    logic [15:0]           shift_res;
    logic [15:0]           v_abs;
    logic [15:0]           val_abs;
    logic [15:0]           rnd_step;
    logic                  ev_have;

    function automatic logic [6:0] clamp7(input logic signed [9:0] n);
        if (n < 0) begin
            return 7'd0;
        end else if (n > 10'sd127) begin
            return 7'd127;
        end
        return n[6:0];
    endfunction

    stci_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        c         = ent_reg.cmd;
        a         = ent_reg.acc;
        b0        = a[7:0];
        val       = a[23:8];
        vid_ok    = ({1'b0, a[7:0]} < 9'(NUM_VARS));
        vid       = a[VI_W-1:0];
        v         = vid_ok ? var_reg[vid] : 16'sd0;
        target    = ADDR_WIDTH'(a[TGT_W-1:0]);
        lvl_m1    = level_reg - SL_W'(1);
        top_idx   = lvl_m1[SI_W-1:0];
        cnt_dec   = stk_count_reg[top_idx] - 8'd1;
        note_sum  = $signed({3'b000, c[6:0]}) + $signed({{2{trans_reg[7]}}, trans_reg});
        porta_sum = $signed({2'b00, b0}) + $signed({{2{trans_reg[7]}}, trans_reg});
        note_clamp  = clamp7(note_sum);
        porta_clamp = clamp7(porta_sum);
        product   = v * val;
        shift_n   = -{val[15], val};
        if (val < 0) begin
            if (shift_n >= 17'd15) begin
                shift_res = {16{v[15]}};
            end else begin
                shift_res = v >>> shift_n[3:0];
            end
        end else if (val >= 16'sd16) begin
            shift_res = 16'd0;
        end else begin
            shift_res = v << val[3:0];
        end
        v_abs    = v[15] ? 16'(-v) : v;
        val_abs  = val[15] ? 16'(-val) : val;
        rnd_step = {1'b0, rnd_reg[15:1]} ^ (rnd_reg[0] ? 16'hB400 : 16'h0000);
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        level_next   = level_reg;
        flag_next    = flag_reg;
        trans_next   = trans_reg;
        rnd_next     = rnd_reg;
        ev_kind_next = ev_kind_reg;
        ev_idx_next  = ev_idx_reg;
        ev_val_next  = ev_val_reg;
        ev_long_next = ev_long_reg;
        dvar_next    = dvar_reg;
        dmod_next    = dmod_reg;
        dneg_next    = dneg_reg;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        var_we       = 1'b0;
        var_widx     = vid;
        var_wdata    = 16'd0;
        stk_we       = 1'b0;
        stk_widx     = level_reg[SI_W-1:0];
        stk_waddr    = addr_reg;
        stk_wcount   = 8'd0;
        stk_wloop    = 1'b0;
        div_start    = 1'b0;
        div_dvd      = v_abs;
        div_dvs      = {1'b0, val_abs};
        ev_have      = 1'b0;

        if (byte_taken) begin
            addr_next = addr_reg + ADDR_WIDTH'(1);
        end
        if (cfg.addr_load) begin
            addr_next = cfg.addr_value;
        end
        if (cfg.seed_load) begin
            rnd_next = cfg.seed_value;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ev_have      = 1'b1;
                ev_kind_next = EV_PARAM;
                ev_idx_next  = 8'd0;
                ev_val_next  = 16'd0;
                ev_long_next = 32'd0;
                if (ent_reg.kind == ENT_ERR_LEN) begin
                    ev_kind_next = EV_ERROR;
                    ev_idx_next  = ERR_NO_LENGTH;
                end else if (ent_reg.kind == ENT_UNKNOWN) begin
                    ev_kind_next = EV_UNKNOWN;
                    ev_idx_next  = a[7:0];
                    ev_val_next  = {8'd0, c};
                end else if (c < CMD_WAIT) begin
                    ev_kind_next = EV_NOTE;
                    ev_idx_next  = {1'b0, note_clamp};
                    ev_val_next  = {8'd0, ent_reg.vel};
                    ev_long_next = a;
                end else if (var_group(c)) begin
                    ev_have = 1'b0;
                    if (!vid_ok) begin
                        ev_have      = 1'b1;
                        ev_kind_next = EV_ERROR;
                        ev_idx_next  = ERR_VAR_RANGE;
                    end else begin
                        unique case (c)
                            CMD_VAR_SET: begin
                                var_we    = 1'b1;
                                var_wdata = val;
                            end
                            CMD_VAR_ADD: begin
                                var_we    = 1'b1;
                                var_wdata = v + val;
                            end
                            CMD_VAR_SUB: begin
                                var_we    = 1'b1;
                                var_wdata = v - val;
                            end
                            CMD_VAR_MUL: begin
                                var_we    = 1'b1;
                                var_wdata = product[15:0];
                            end
                            CMD_VAR_DIV: begin
                                if (val != 16'sd0) begin
                                    div_start = 1'b1;
                                    dmod_next = 1'b0;
                                    dneg_next = v[15] ^ val[15];
                                end
                            end
                            CMD_VAR_SHIFT: begin
                                var_we    = 1'b1;
                                var_wdata = shift_res;
                            end
                            CMD_VAR_RAND: begin
                                rnd_next  = rnd_step;
                                div_start = 1'b1;
                                div_dvd   = rnd_step;
                                div_dvs   = {1'b0, val_abs} + 17'd1;
                                dmod_next = 1'b1;
                                dneg_next = val[15];
                            end
                            CMD_CMP_EQ: flag_next = (v == val);
                            CMD_CMP_GE: flag_next = (v >= val);
                            CMD_CMP_GT: flag_next = (v > val);
                            CMD_CMP_LE: flag_next = (v <= val);
                            CMD_CMP_LT: flag_next = (v < val);
                            default:    flag_next = (v != val);
                        endcase
                        dvar_next = vid;
                    end
                end else begin
                    unique case (c)
                        CMD_WAIT: begin
                            ev_kind_next = EV_WAIT;
                            ev_long_next = a;
                        end
                        CMD_PROGRAM: begin
                            ev_kind_next = EV_PROGRAM;
                            ev_long_next = a;
                        end
                        CMD_TRACK: begin
                            ev_kind_next = EV_TRACK;
                            ev_idx_next  = b0;
                            ev_long_next = {8'd0, a[31:8]};
                        end
                        CMD_JUMP: begin
                            addr_next    = target;
                            ev_kind_next = EV_JUMP;
                            ev_long_next = 32'(target);
                        end
                        CMD_CALL, CMD_LOOP_START: begin
                            if (level_reg == SL_W'(STACK_DEPTH)) begin
                                ev_kind_next = EV_ERROR;
                                ev_idx_next  = ERR_STACK_FULL;
                            end else begin
                                stk_we     = 1'b1;
                                level_next = level_reg + SL_W'(1);
                                if (c == CMD_CALL) begin
                                    addr_next    = target;
                                    ev_kind_next = EV_JUMP;
                                    ev_long_next = 32'(target);
                                end else begin
                                    stk_wcount = b0;
                                    stk_wloop  = 1'b1;
                                    ev_have    = 1'b0;
                                end
                            end
                        end
                        CMD_PAN: begin
                            ev_idx_next = PID_PAN;
                            ev_val_next = {8'd0, b0} - 16'd64;
                        end
                        CMD_VOLUME: begin
                            ev_idx_next = PID_VOLUME;
                            ev_val_next = {8'd0, b0};
                        end
                        CMD_ARG_SKIP: begin
                            ev_kind_next = EV_UNKNOWN;
                            ev_idx_next  = CMD_ARG_SKIP;
                        end
                        CMD_TRANSPOSE: begin
                            trans_next  = b0;
                            ev_idx_next = PID_TRANSPOSE;
                            ev_val_next = {{8{b0[7]}}, b0};
                        end
                        CMD_BEND: begin
                            ev_idx_next = PID_BEND;
                            ev_val_next = {{8{b0[7]}}, b0};
                        end
                        CMD_BEND_RANGE: begin
                            ev_idx_next = PID_BEND_RANGE;
                            ev_val_next = {8'd0, b0};
                        end
                        CMD_PRIORITY: begin
                            ev_idx_next = PID_PRIORITY;
                            ev_val_next = {8'd0, b0};
                        end
                        CMD_NOTE_WAIT: begin
                            ev_idx_next = PID_NOTE_WAIT;
                            ev_val_next = {15'd0, b0 != 8'd0};
                        end
                        CMD_TIE: begin
                            ev_kind_next = EV_TIE;
                            ev_val_next  = {15'd0, b0 != 8'd0};
                        end
                        CMD_PORTA_START: begin
                            ev_idx_next = PID_PORTA_START;
                            ev_val_next = {9'd0, porta_clamp};
                        end
                        CMD_PORTA: begin
                            ev_idx_next = PID_PORTA;
                            ev_val_next = {15'd0, b0 != 8'd0};
                        end
                        CMD_EXPRESSION: begin
                            ev_idx_next = PID_EXPRESSION;
                            ev_val_next = {8'd0, b0};
                        end
                        CMD_PRINT: begin
                            ev_have = 1'b0;
                            if (!vid_ok) begin
                                ev_have      = 1'b1;
                                ev_kind_next = EV_ERROR;
                                ev_idx_next  = ERR_VAR_RANGE;
                            end
                        end
                        CMD_MOD_DELAY: begin
                            ev_idx_next = PID_MOD_DELAY;
                            ev_val_next = a[15:0];
                        end
                        CMD_TEMPO: begin
                            ev_kind_next = EV_TEMPO;
                            ev_val_next  = a[15:0];
                        end
                        CMD_SWEEP: begin
                            ev_idx_next = PID_SWEEP;
                            ev_val_next = a[15:0];
                        end
                        CMD_LOOP_END, CMD_RETURN: begin
                            if (level_reg == SL_W'(0)) begin
                                ev_kind_next = EV_ERROR;
                                ev_idx_next  = ERR_STACK_EMPTY;
                            end else if (stk_loop_reg[top_idx] != (c == CMD_LOOP_END)) begin
                                ev_kind_next = EV_ERROR;
                                ev_idx_next  = ERR_STACK_TYPE;
                            end else if (c == CMD_LOOP_END && cnt_dec == 8'd0) begin
                                // Loop count ran out: drop the frame and fall through.
                                level_next = lvl_m1;
                                ev_have    = 1'b0;
                            end else begin
                                if (c == CMD_LOOP_END) begin
                                    stk_we     = 1'b1;
                                    stk_widx   = top_idx;
                                    stk_waddr  = stk_addr_reg[top_idx];
                                    stk_wcount = cnt_dec;
                                    stk_wloop  = 1'b1;
                                end else begin
                                    level_next = lvl_m1;
                                end
                                addr_next    = stk_addr_reg[top_idx];
                                ev_kind_next = EV_JUMP;
                                ev_long_next = 32'(stk_addr_reg[top_idx]);
                            end
                        end
                        CMD_END: begin
                            ev_kind_next = EV_STOP;
                        end
                        default: begin
                            if (c >= CMD_MOD_FIRST && c <= CMD_ENV_LAST) begin
                                ev_idx_next = c - CMD_MOD_FIRST + PID_MOD_BASE;
                                ev_val_next = {8'd0, b0};
                            end else begin
                                ev_have = 1'b0;
                            end
                        end
                    endcase
                end
                if (div_start) begin
                    state_next = ST_DIV;
                end else if (ev_have) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    var_we     = 1'b1;
                    var_widx   = dvar_reg;
                    if (dmod_reg) begin
                        var_wdata = dneg_reg ? 16'(-div_rem[15:0]) : div_rem[15:0];
                    end else begin
                        var_wdata = dneg_reg ? 16'(-div_quo) : div_quo;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign status.compare_flag = flag_reg;
    assign status.back_idle    = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_arg_index  = m_idx_reg;
    assign m_arg_value  = m_val_reg;
    assign m_arg_long   = m_long_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            level_reg   <= '0;
            flag_reg    <= 1'b0;
            trans_reg   <= 8'd0;
            rnd_reg     <= 16'd1;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VARS; i++) begin
                var_reg[i] <= 16'd0;
            end
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            level_reg   <= level_next;
            flag_reg    <= flag_next;
            trans_reg   <= trans_next;
            rnd_reg     <= rnd_next;
            m_valid_reg <= m_valid_next;
            if (var_we) begin
                var_reg[var_widx] <= var_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= head;
        end
        ev_kind_reg <= ev_kind_next;
        ev_idx_reg  <= ev_idx_next;
        ev_val_reg  <= ev_val_next;
        ev_long_reg <= ev_long_next;
        dvar_reg    <= dvar_next;
        dmod_reg    <= dmod_next;
        dneg_reg    <= dneg_next;
        if (out_load) begin
            m_kind_reg <= ev_kind_reg;
            m_idx_reg  <= ev_idx_reg;
            m_val_reg  <= ev_val_reg;
            m_long_reg <= ev_long_reg;
        end
        if (stk_we) begin
            stk_addr_reg[stk_widx]  <= stk_waddr;
            stk_count_reg[stk_widx] <= stk_wcount;
            stk_loop_reg[stk_widx]  <= stk_wloop;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= SL_W'(STACK_DEPTH))
        else $error("stack level beyond stack depth");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("event not presented after emit");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE && !q_empty))
        else $error("queue popped while busy or empty");

endmodule

FILE: sv/sequence_track_command_interpreter_unit.sv
`timescale 1ns / 1ps

// Track command interpreter: takes one byte of sequence data per transaction
// on the s_ channel and delivers at most one event per finished command on the
// m_ channel. The front parser accepts one byte per cycle unless the queue is
// full or it waits on the executor, and hands finished commands to the
// executor through a two-entry queue. Variable divide and random commands
// use the bit-serial divider in the executor. After a jump, call, return,
// loop or variable command the parser holds s_ready low until the executor
// has finished that command, so the next byte sees the updated address and
// compare flag. Registers: start_address at 0x0, random_seed at 0x4; writing
// either one also loads the current address or the random generator.
module sequence_track_command_interpreter_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_seq_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_kind,
    output logic [7:0]         m_arg_index,
    output logic signed [15:0] m_arg_value,
    output logic [31:0]        m_arg_long,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import stci_pkg::*;

    logic [23:0] start_reg;
    logic [15:0] seed_reg;
    logic        wr_en;
    cfg_t        cfg;
    status_t     status;
    entry_t      push_entry;
    entry_t      head;
    logic        push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    logic        byte_taken;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = paddr[2] ? {16'd0, seed_reg} : {8'd0, start_reg};

    assign cfg.addr_load  = wr_en && !paddr[2];
    assign cfg.addr_value = ADDR_WIDTH'(pwdata[TGT_W-1:0]);
    assign cfg.seed_load  = wr_en && paddr[2];
    assign cfg.seed_value = pwdata[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 24'd0;
            seed_reg  <= 16'd1;
        end else begin
            if (cfg.addr_load) begin
                start_reg <= pwdata[23:0];
            end
            if (cfg.seed_load) begin
                seed_reg <= pwdata[15:0];
            end
        end
    end

    stci_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_seq_byte (s_seq_byte),
        .status     (status),
        .q_full     (q_full),
        .q_empty    (q_empty),
        .push       (push),
        .push_entry (push_entry),
        .byte_taken (byte_taken)
    );

    stci_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    stci_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .byte_taken   (byte_taken),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_arg_index  (m_arg_index),
        .m_arg_value  (m_arg_value),
        .m_arg_long   (m_arg_long)
    );

endmodule
